// ===== hw/rtl/rmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsd_pkg: shared constants for the running mean and deviation block
// Field widths and default sizes used by the top level and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsd_pkg;

    // Sample and mean are signed fixed point, 32 bits wide.
    localparam int SAMPLE_W = 32;
    // Difference of two samples needs one extra bit.
    localparam int DELTA_W = SAMPLE_W + 1;
    // Sum of squared deviations, unsigned.
    localparam int SUM_W = 2 * SAMPLE_W;
    // Integer square root of the variance.
    localparam int ROOT_W = SUM_W / 2;
    // Width of the count field on the result channel.
    localparam int COUNT_OUT_W = 16;
    // Default width of the internal sample counter.
    localparam int DEFAULT_COUNT_BITS = 16;

endpackage

`default_nettype wire

// ===== hw/rtl/rmsd_divider.sv =====
// ----------------------------------------------------------------------------
// rmsd_divider: bit-serial restoring divider
// Produces one quotient bit per cycle. A short operation divides a half-width
// dividend in half the number of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_divider #(
    parameter int DIVISOR_W = rmsd_pkg::DEFAULT_COUNT_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       short_op,
    input  wire logic [rmsd_pkg::SUM_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]       divisor,
    output logic                            done,
    output logic [rmsd_pkg::SUM_W-1:0]      quotient
);

    localparam int SUM_W = rmsd_pkg::SUM_W;
    localparam int HALF_W = SUM_W / 2;
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;
    logic [DIVISOR_W-1:0] rem_next;

    // The dividend bits enter the partial remainder from the top of the
    // quotient register while quotient bits fill it from the bottom.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_op ? CNT_W'(HALF_W) : CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= short_op ? {dividend[HALF_W-1:0], {HALF_W{1'b0}}} : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rmsd_multiplier.sv =====
// ----------------------------------------------------------------------------
// rmsd_multiplier: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle and builds the full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_multiplier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rmsd_pkg::SAMPLE_W-1:0] mcand,
    input  wire logic [rmsd_pkg::SAMPLE_W-1:0] mplier,
    output logic                               done,
    output logic [rmsd_pkg::SUM_W-1:0]         product
);

    localparam int W = rmsd_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [W-1:0]     mcand_reg;
    logic [W-1:0]     hi_reg;
    logic [W-1:0]     lo_reg;

    logic [W:0]       partial;

    // Add the multiplicand to the upper half when the current multiplier bit
    // is set, then shift the whole product right by one.
    assign partial = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : {(W + 1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= partial[W:1];
            lo_reg <= {partial[0], lo_reg[W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/rmsd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmsd_sqrt: digit-serial integer square root
// Takes two radicand bits per cycle and produces one root bit per cycle,
// rounding down.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rmsd_pkg::SUM_W-1:0]  radicand,
    output logic                             done,
    output logic [rmsd_pkg::ROOT_W-1:0]      root
);

    localparam int SUM_W = rmsd_pkg::SUM_W;
    localparam int ROOT_W = rmsd_pkg::ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  src_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Before the last step the remainder stays below twice a 31-bit root, so
    // its low ROOT_W bits carry all of it into the shifted candidate.
    assign cand  = {rem_reg[ROOT_W-1:0], src_reg[SUM_W-1:SUM_W-2]};
    assign trial = {root_reg, 2'b01};
    assign take  = cand >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            src_reg  <= {src_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= take ? (cand - trial) : cand;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/running_mean_stddev.sv =====
// ----------------------------------------------------------------------------
// running_mean_stddev: online mean and population standard deviation
// Updates a running mean and a sum of squared deviations per sample and
// reports the mean, the standard deviation, the count and a saturation flag.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the sample channel (sample_valid, sample_ready,
// sample) and each one produces exactly one result request on the result
// channel (result_valid, result_ready, mean, deviation, sample_count,
// saturated). The block works on one sample at a time. sample_ready is high
// only while the sequencer is idle; a sample is taken when sample_valid and
// sample_ready are both high.
// Sequence: a sample is taken only in idle, and the next one only after the
// result of the last one has been loaded into the output register. The work
// is done by four serial units that run one after the other: a 32-step
// divide of the deviation by the count, a 32-step shift-add multiply, a
// 64-step divide of the squared sum by the count and a 32-step square root,
// each started by the sequencer, after which the result is loaded into the
// output register.
// Stalls: results sit in an output register, so the next sample is accepted
// and processed while an earlier result still waits. A finished result waits
// in the sequencer only if the output register is still full.
// Reset: count, mean, squared sum and the saturation flag clear to zero,
// the result channel goes empty and the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_stddev #(
    parameter int COUNT_BITS = rmsd_pkg::DEFAULT_COUNT_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   sample_valid,
    output logic                                        sample_ready,
    input  wire logic signed [rmsd_pkg::SAMPLE_W-1:0]   sample,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic signed [rmsd_pkg::SAMPLE_W-1:0]        mean,
    output logic [rmsd_pkg::ROOT_W-1:0]                 deviation,
    output logic [rmsd_pkg::COUNT_OUT_W-1:0]            sample_count,
    output logic                                        saturated
);

    localparam int SAMPLE_W = rmsd_pkg::SAMPLE_W;
    localparam int DELTA_W = rmsd_pkg::DELTA_W;
    localparam int SUM_W = rmsd_pkg::SUM_W;
    localparam int ROOT_W = rmsd_pkg::ROOT_W;
    localparam int COUNT_OUT_W = rmsd_pkg::COUNT_OUT_W;
    localparam int CNT_EXT_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV1_GO = 4'd1;
    localparam logic [3:0] S_DIV1    = 4'd2;
    localparam logic [3:0] S_MUL_GO  = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_DIV2_GO = 4'd5;
    localparam logic [3:0] S_DIV2    = 4'd6;
    localparam logic [3:0] S_SQRT    = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    // Sequencer and statistics state.
    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SAMPLE_W-1:0]   mean_reg;
    logic [SUM_W-1:0]      ssum_reg;
    logic                  sticky_reg;

    // Per-sample working registers.
    logic [SAMPLE_W-1:0]   x_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic                  neg_reg;
    logic [ROOT_W-1:0]     root_reg;

    // Output register.
    logic                  result_valid_reg;
    logic [SAMPLE_W-1:0]   mean_out_reg;
    logic [ROOT_W-1:0]     dev_out_reg;
    logic [COUNT_OUT_W-1:0] cnt_out_reg;
    logic                  sat_out_reg;

    // Datapath between the units.
    logic                  sample_take;
    logic                  out_free;
    logic                  count_full;
    logic [DELTA_W-1:0]    delta_in;
    logic [SAMPLE_W-1:0]   delta_mag;
    logic [DELTA_W-1:0]    delta2;
    logic [SAMPLE_W-1:0]   delta2_mag;
    logic [DELTA_W-1:0]    mean_sum;
    logic [SAMPLE_W-1:0]   quot_low;
    logic [SUM_W:0]        ssum_add;
    logic [CNT_EXT_W-1:0]  count_ext;

    logic                  div_start;
    logic                  div_short;
    logic [SUM_W-1:0]      div_dividend;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quotient;
    logic                  mul_start;
    logic                  mul_done;
    logic [SUM_W-1:0]      mul_product;
    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;

    assign sample_ready = (state_reg == S_IDLE);
    assign sample_take  = sample_valid && sample_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign count_full   = (count_reg == {COUNT_BITS{1'b1}});

    // Deviation of the new sample from the old mean, one bit wider than a
    // sample so it never wraps.
    assign delta_in  = {sample[SAMPLE_W-1], sample} - {mean_reg[SAMPLE_W-1], mean_reg};
    assign delta_mag = delta_reg[DELTA_W-1] ? SAMPLE_W'(-delta_reg)
                                            : delta_reg[SAMPLE_W-1:0];

    // Deviation from the updated mean. Its magnitude never exceeds that of
    // the first deviation, so it also fits in a sample width.
    assign delta2     = {x_reg[SAMPLE_W-1], x_reg} - {mean_reg[SAMPLE_W-1], mean_reg};
    assign delta2_mag = delta2[DELTA_W-1] ? SAMPLE_W'(-delta2) : delta2[SAMPLE_W-1:0];

    // The quotient has the magnitude of delta / n; applying the sign of delta
    // gives truncation toward zero. The new mean stays between the old mean
    // and the sample, so the low bits are exact.
    assign quot_low = div_quotient[SAMPLE_W-1:0];
    assign mean_sum = delta_reg[DELTA_W-1]
                    ? ({mean_reg[SAMPLE_W-1], mean_reg} - {1'b0, quot_low})
                    : ({mean_reg[SAMPLE_W-1], mean_reg} + {1'b0, quot_low});

    assign ssum_add = {1'b0, ssum_reg} + {1'b0, mul_product};

    // The divider is shared: first the deviation over the count, then the
    // squared sum over the count.
    assign div_start    = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    assign div_short    = (state_reg == S_DIV1_GO);
    assign div_dividend = div_short ? {{(SUM_W - SAMPLE_W){1'b0}}, delta_mag} : ssum_reg;
    assign mul_start    = (state_reg == S_MUL_GO);
    assign sqrt_start   = (state_reg == S_DIV2) && div_done;

    assign count_ext = CNT_EXT_W'(count_reg);

    rmsd_divider #(
        .DIVISOR_W (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .short_op (div_short),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rmsd_multiplier u_multiplier (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (delta_mag),
        .mplier  (delta2_mag),
        .done    (mul_done),
        .product (mul_product)
    );

    rmsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quotient),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Sequencer transitions.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = S_DIV1_GO;
                end
            end
            S_DIV1_GO:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV2_GO;
                end
            end
            S_DIV2_GO:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and statistics state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            mean_reg         <= '0;
            ssum_reg         <= '0;
            sticky_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (sample_take)
            begin
                // A full counter holds its value and marks saturation.
                if (count_full)
                begin
                    sticky_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
            end

            if ((state_reg == S_DIV1) && div_done)
            begin
                mean_reg <= mean_sum[SAMPLE_W-1:0];
            end

            if ((state_reg == S_MUL) && mul_done)
            begin
                if (neg_reg)
                begin
                    // With truncating division this is reached only with a zero product, but
                    // any negative product is subtracted with the sum floored at zero.
                    ssum_reg <= (mul_product > ssum_reg) ? '0 : (ssum_reg - mul_product);
                end
                else if (ssum_add[SUM_W])
                begin
                    ssum_reg   <= {SUM_W{1'b1}};
                    sticky_reg <= 1'b1;
                end
                else
                begin
                    ssum_reg <= ssum_add[SUM_W-1:0];
                end
            end

            if ((state_reg == S_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            x_reg     <= sample;
            delta_reg <= delta_in;
        end

        if (state_reg == S_MUL_GO)
        begin
            neg_reg <= delta_reg[DELTA_W-1] != delta2[DELTA_W-1];
        end

        if ((state_reg == S_SQRT) && sqrt_done)
        begin
            root_reg <= sqrt_root;
        end

        if ((state_reg == S_OUT) && out_free)
        begin
            mean_out_reg <= mean_reg;
            dev_out_reg  <= root_reg;
            cnt_out_reg  <= count_ext[COUNT_OUT_W-1:0];
            sat_out_reg  <= sticky_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign mean         = mean_out_reg;
    assign deviation    = dev_out_reg;
    assign sample_count = cnt_out_reg;
    assign saturated    = sat_out_reg;

endmodule

`default_nettype wire

// ===== dv/running_mean_stddev_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_mean_stddev_tb: self-checking bench for the online statistics block
// Sends signed fixed-point samples through the sample channel with random
// gaps, stalls the result channel at random, and checks every result request
// against an in-bench fixed-point model of the Welford update.
// ----------------------------------------------------------------------------

module running_mean_stddev_tb;

    localparam int SAMPLE_W           = rmsd_pkg::SAMPLE_W;
    localparam int SUM_W              = rmsd_pkg::SUM_W;
    localparam int ROOT_W             = rmsd_pkg::ROOT_W;
    localparam int COUNT_OUT_W        = rmsd_pkg::COUNT_OUT_W;
    localparam int DEFAULT_COUNT_BITS = rmsd_pkg::DEFAULT_COUNT_BITS;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    // No correct run goes this long without a request on either channel: it
    // exceeds one update plus the longest sender gap and the longest result stall.
    localparam int STALL_LIMIT = 5000;
    // Extra cycles at the end in which no further result may appear.
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_SAMPLES = 1030;
    // The last stretch of random samples uses the full input range. Those
    // drive the squared sum into saturation, so they are kept to the end.
    localparam int WIDE_TAIL = 40;

    // One expected result request.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [ROOT_W-1:0]          deviation;
        logic [COUNT_OUT_W-1:0]     sample_count;
        logic                       saturated;
    } stats_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the running statistics, works out the
    // result of each accepted sample and checks the results in order.
    // ------------------------------------------------------------------------
    class welford_scoreboard;
        bit [DEFAULT_COUNT_BITS-1:0] n_seen;
        longint                      mean_q;
        bit [SUM_W-1:0]              sq_sum;
        bit                          sat_flag;
        stats_t                      expected_q[$];
        int                          errors;

        function void clear();
            n_seen   = '0;
            mean_q   = 0;
            sq_sum   = '0;
            sat_flag = 1'b0;
            errors   = 0;
            expected_q.delete();
        endfunction

        // Largest r with r * r <= v, built one bit at a time from the top.
        function bit [ROOT_W-1:0] root_floor(bit [SUM_W-1:0] v);
            bit [ROOT_W-1:0] r;
            bit [ROOT_W-1:0] trial;
            r = '0;
            for (int i = ROOT_W - 1; i >= 0; i--)
            begin
                trial = r | (ROOT_W'(1) << i);
                if (SUM_W'(trial) * SUM_W'(trial) <= v)
                    r = trial;
            end
            return r;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x_in);
            longint         x;
            longint         delta;
            longint         delta2;
            bit [SUM_W-1:0] mag_a;
            bit [SUM_W-1:0] mag_b;
            bit [SUM_W-1:0] prod;
            stats_t         e;
            x = longint'(x_in);
            // The count holds at its maximum and flags saturation.
            if (n_seen == '1)
                sat_flag = 1'b1;
            else
                n_seen++;
            delta  = x - mean_q;
            // Signed division truncates toward zero, as the block does.
            mean_q = mean_q + delta / longint'(n_seen);
            delta2 = x - mean_q;
            mag_a  = (delta < 0) ? SUM_W'(-delta) : SUM_W'(delta);
            mag_b  = (delta2 < 0) ? SUM_W'(-delta2) : SUM_W'(delta2);
            prod   = mag_a * mag_b;
            if ((delta < 0) != (delta2 < 0))
                sq_sum = (prod > sq_sum) ? '0 : sq_sum - prod;
            else if (sq_sum > ~prod)
            begin
                sq_sum   = '1;
                sat_flag = 1'b1;
            end
            else
                sq_sum = sq_sum + prod;
            e.mean         = mean_q[SAMPLE_W-1:0];
            e.deviation    = root_floor(sq_sum / SUM_W'(n_seen));
            e.sample_count = COUNT_OUT_W'(n_seen);
            e.saturated    = sat_flag;
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] m, logic [ROOT_W-1:0] d,
                                   logic [COUNT_OUT_W-1:0] c, logic s);
            stats_t e;
            if (expected_q.size() == 0)
            begin
                $error("result request with no sample outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (m !== e.mean)
            begin
                $error("mean: expected %0d, actual %0d", e.mean, m);
                errors++;
            end
            if (d !== e.deviation)
            begin
                $error("deviation: expected %0d, actual %0d", e.deviation, d);
                errors++;
            end
            if (c !== e.sample_count)
            begin
                $error("sample_count: expected %0d, actual %0d", e.sample_count, c);
                errors++;
            end
            if (s !== e.saturated)
            begin
                $error("saturated: expected %0b, actual %0b", e.saturated, s);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] mean;
    logic [ROOT_W-1:0]          deviation;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic                       saturated;

    welford_scoreboard sb;
    bit                sender_burst = 1'b0;
    int                idle_cycles = 0;

    running_mean_stddev uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mean         (mean),
        .deviation    (deviation),
        .sample_count (sample_count),
        .saturated    (saturated)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Mostly short gaps, now and then a long one so that idle time lands in
    // every stage of the serial divide, multiply and square-root sequence.
    function automatic int pick_gap(int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 40);
        return $urandom_range(100, longest);
    endfunction

    // Offers one sample request and returns on the edge that accepts it.
    // Valid is lowered only when a gap follows, so a back-to-back request
    // never sees valid dropped and raised in one time step.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = sender_burst ? 0 : pick_gap(300);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    // Result side: random stretches of ready and stall. A long stall lets the
    // next sample finish while a result still waits in the output register.
    // Now and then ready stays high for a long run.
    initial
    begin
        int hold;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                hold = $urandom_range(300, 800);
            else
                hold = $urandom_range(1, 20);
            result_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            hold = pick_gap(500);
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Both channels are observed at the clock edge, where a request is
    // accepted; the values seen are those that held up to that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                sb.note_sample(sample);
            if (result_valid && result_ready)
                sb.check_result(mean, deviation, sample_count, saturated);
        end
    end

    // Watchdog: too long without any request on either channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL running_mean_stddev");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic signed [SAMPLE_W-1:0] directed[$];
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] center;
        int r;
        int w;

        sb = new;
        sb.clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first sample sets the mean outright, the second
        // zero has no deviation at all. Odd small values with negative
        // deviations check that the mean step truncates toward zero rather
        // than rounding down. The two range extremes pull the mean far in both
        // directions and toggle every input bit.
        directed = '{
            32'sd0, 32'sd0, 32'sh0001_0000, -32'sh0001_0000, 32'sd1, -32'sd1,
            32'sd7, -32'sd7, -32'sd3, 32'sd2, 32'sd100000, -32'sd100000,
            32'sd12345678, -32'sd12345678, 32'sd5,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sh0000_8000
        };
        foreach (directed[i])
            send_sample(directed[i]);

        // Random part. Samples cluster around a center that moves every so
        // often, with spreads of many sizes, small steps from the previous
        // sample and exact repeats. The full-range tail pushes the squared
        // sum into saturation and checks that the flag stays set.
        prev   = directed[directed.size() - 1];
        center = '0;
        for (int i = 0; i < RANDOM_SAMPLES; i++)
        begin
            if (i % 64 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            if (i % 50 == 0)
                center = $signed($urandom) >>> $urandom_range(6, 14);
            r = $urandom_range(0, 99);
            if (i >= RANDOM_SAMPLES - WIDE_TAIL)
                x = $signed($urandom);
            else if (r < 65)
            begin
                w = $urandom_range(1, 20);
                x = center + ($signed($urandom) >>> (SAMPLE_W - w));
            end
            else if (r < 85)
                x = prev + $signed(SAMPLE_W'($urandom_range(0, 6))) - 3;
            else if (r < 95)
                x = prev;
            else
                x = center;
            send_sample(x);
            prev = x;
        end
        sample_valid <= 1'b0;
        sender_burst = 1'b0;

        // Wait for every outstanding result, then watch for strays. The first
        // edge lets the monitor note the last sample before the count is read.
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS running_mean_stddev");
        else
            $display("FAIL running_mean_stddev");
        $finish;
    end

endmodule
